// ----- design/gamepad_report_decoder_top_assert.svh -----
// Assertion macros used by the gamepad report decoder port checker.
// Needs a clk and an active-low arst_n in scope where used.
`ifndef GAMEPAD_REPORT_DECODER_TOP_ASSERT_SVH
`define GAMEPAD_REPORT_DECODER_TOP_ASSERT_SVH

// Check a same-cycle implication while out of reset.
`define GRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle while out of reset.
`define GRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/grd_pkg.sv -----
// Shared types, constants and helpers of the gamepad report decoder.
// No dependencies.
package grd_pkg;

	localparam int UNITS_PER_G = 512;
	localparam int UG_W = $clog2(UNITS_PER_G + 1);
	localparam int DVD_W = 16 + UG_W;
	localparam int PROD_W = 17 + UG_W + 1;
	localparam int CAL_SHIFT = 14;
	localparam int CAL_ROUND = (1 << CAL_SHIFT) - 1;
	localparam logic [17:0] RECIP6 = 18'd174763;
	localparam int RECIP6_SHIFT = 20;
	localparam logic [7:0] ID_FULL = 8'h30;
	localparam logic [7:0] ID_NULL = 8'h00;
	localparam logic signed [15:0] SCALE_RESET = 16'sh4000;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCL_Z = 3'd5;

	typedef struct packed {
		logic [7:0] report_id;
		logic [23:0] raw_buttons;
		logic [23:0] left_stick_raw;
		logic [23:0] right_stick_raw;
		logic [47:0] imu_sample_first;
		logic [47:0] imu_sample_second;
		logic [47:0] imu_sample_third;
	} grd_in_t;

	typedef struct packed {
		logic accepted;
		logic [23:0] buttons;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} grd_out_t;

	typedef struct packed {
		logic accepted;
		logic [23:0] buttons;
		logic [15:0] left_x;
		logic [15:0] left_y;
		logic [15:0] right_x;
		logic [15:0] right_y;
		logic [2:0] avg_neg;
		logic [2:0][15:0] avg_mag;
	} grd_item_t;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0][15:0] mag;
	} grd_div_t;

	typedef struct packed {
		logic accepted;
		logic [23:0] buttons;
		logic [15:0] left_x;
		logic [15:0] left_y;
		logic [15:0] right_x;
		logic [15:0] right_y;
		logic [2:0] res_neg;
	} grd_side_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [DVD_W-1:0] dvd;
	} grd_step_t;

	function automatic logic [15:0] stick_widen(input logic [11:0] v);
		return {~v[11], v[10:0], v[3:0]};
	endfunction

	function automatic grd_step_t div_step(input logic [15:0] rem, input logic [DVD_W-1:0] dvd,
			input logic [15:0] dm);
		logic [16:0] t;
		grd_step_t r;
		t = {rem, dvd[DVD_W-1]};
		if (t >= {1'b0, dm}) begin
			r.rem = 16'(t - {1'b0, dm});
			r.dvd = {dvd[DVD_W-2:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.dvd = {dvd[DVD_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(input logic neg, input logic [DVD_W-1:0] q);
		if (neg) begin
			if (q > DVD_W'(32768)) return 16'h8000;
			return 16'(~q + 1'b1);
		end
		if (q > DVD_W'(32767)) return 16'h7fff;
		return q[15:0];
	endfunction

endpackage

// ----- design/grd_front.sv -----
// Front end: calibration registers, report check, stick widening, sample averaging.
// Uses grd_pkg; feeds grd_queue and the divisors of grd_back.
module grd_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input grd_pkg::grd_in_t in_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic q_full,
	output logic push,
	output grd_pkg::grd_item_t push_item,
	output grd_pkg::grd_div_t div_cfg
);

	logic signed [15:0] ofs_q [3];
	logic signed [15:0] scl_q [3];
	logic ok;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;
	assign push = in_valid & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ofs_q[i] <= '0;
				scl_q[i] <= grd_pkg::SCALE_RESET;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				grd_pkg::CFG_OFS_X: ofs_q[0] <= cfg_data;
				grd_pkg::CFG_OFS_Y: ofs_q[1] <= cfg_data;
				grd_pkg::CFG_OFS_Z: ofs_q[2] <= cfg_data;
				grd_pkg::CFG_SCL_X: scl_q[0] <= cfg_data;
				grd_pkg::CFG_SCL_Y: scl_q[1] <= cfg_data;
				grd_pkg::CFG_SCL_Z: scl_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic signed [16:0] diff;
		logic signed [grd_pkg::PROD_W-1:0] prod;
		logic signed [grd_pkg::PROD_W-1:0] adj;
		logic [15:0] d16;
		for (int a = 0; a < 3; a++) begin
			diff = 17'(scl_q[a]) - 17'(ofs_q[a]);
			prod = grd_pkg::PROD_W'(diff) * $signed(grd_pkg::PROD_W'(grd_pkg::UNITS_PER_G));
			adj = prod + (prod[grd_pkg::PROD_W-1] ? grd_pkg::PROD_W'(grd_pkg::CAL_ROUND) : '0);
			adj = adj >>> grd_pkg::CAL_SHIFT;
			d16 = adj[15:0];
			if (d16 == '0) d16 = 16'd1;
			div_cfg.neg[a] = d16[15];
			div_cfg.mag[a] = d16[15] ? 16'(~d16 + 1'b1) : d16;
		end
	end

	always_comb begin
		logic signed [18:0] sa, sb, sc, sum;
		logic [17:0] mag;
		logic [35:0] qp;
		ok = (in_data.report_id == grd_pkg::ID_FULL) || (in_data.report_id == grd_pkg::ID_NULL);
		push_item = '0;
		push_item.accepted = ok;
		if (ok) begin
			push_item.buttons = in_data.raw_buttons;
			push_item.left_x = grd_pkg::stick_widen(in_data.left_stick_raw[11:0]);
			push_item.left_y = grd_pkg::stick_widen(in_data.left_stick_raw[23:12]);
			push_item.right_x = grd_pkg::stick_widen(in_data.right_stick_raw[11:0]);
			push_item.right_y = grd_pkg::stick_widen(in_data.right_stick_raw[23:12]);
		end
		for (int a = 0; a < 3; a++) begin
			sa = 19'($signed(in_data.imu_sample_first[16*a +: 16]));
			sb = 19'($signed(in_data.imu_sample_second[16*a +: 16]));
			sc = 19'($signed(in_data.imu_sample_third[16*a +: 16]));
			sum = (sa <<< 1) + sa + (sb <<< 1) + sc;
			mag = sum[18] ? 18'(-sum) : 18'(sum);
			qp = {18'd0, mag} * {18'd0, grd_pkg::RECIP6};
			if (ok) begin
				push_item.avg_neg[a] = sum[18];
				push_item.avg_mag[a] = qp[grd_pkg::RECIP6_SHIFT +: 16];
			end
		end
	end

endmodule

// ----- design/grd_queue.sv -----
// Short queue between the front end and the divider pipeline.
// Uses grd_pkg for the entry type and depth.
module grd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input grd_pkg::grd_item_t push_item,
	output logic full,
	input logic pop,
	output grd_pkg::grd_item_t pop_item,
	output logic empty
);

	grd_pkg::grd_item_t entry_q [grd_pkg::Q_DEPTH];
	logic [grd_pkg::Q_PTR_W-1:0] wr_q, rd_q;
	logic [grd_pkg::Q_PTR_W:0] cnt_q;

	assign full = (cnt_q == (grd_pkg::Q_PTR_W+1)'(grd_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_item = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- design/grd_back.sv -----
// Back end: scale, one-bit-per-stage signed division, saturation and output register.
// Uses grd_pkg; drains grd_queue.
module grd_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input grd_pkg::grd_item_t q_item,
	output logic pop,
	input grd_pkg::grd_div_t div_cfg,
	output logic out_valid,
	input logic out_stall,
	output grd_pkg::grd_out_t out_data
);

	localparam int N = grd_pkg::DVD_W;

	logic en;
	logic vld_s [N+1];
	grd_pkg::grd_side_t side_s [N+1];
	logic [2:0][15:0] rem_s [N+1];
	logic [2:0][N-1:0] dvd_s [N+1];
	logic out_valid_q;
	grd_pkg::grd_out_t out_q;

	assign en = ~(out_valid_q & out_stall);
	assign pop = en & ~q_empty;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= ~q_empty;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].accepted <= q_item.accepted;
			side_s[0].buttons <= q_item.buttons;
			side_s[0].left_x <= q_item.left_x;
			side_s[0].left_y <= q_item.left_y;
			side_s[0].right_x <= q_item.right_x;
			side_s[0].right_y <= q_item.right_y;
			side_s[0].res_neg <= q_item.avg_neg ^ div_cfg.neg;
			for (int a = 0; a < 3; a++) begin
				rem_s[0][a] <= '0;
				dvd_s[0][a] <= N'(q_item.avg_mag[a]) * N'(grd_pkg::UNITS_PER_G);
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		grd_pkg::grd_step_t st [3];
		always_comb begin
			for (int a = 0; a < 3; a++)
				st[a] = grd_pkg::div_step(rem_s[k][a], dvd_s[k][a], div_cfg.mag[a]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				for (int a = 0; a < 3; a++) begin
					rem_s[k+1][a] <= st[a].rem;
					dvd_s[k+1][a] <= st[a].dvd;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.accepted <= side_s[N].accepted;
			out_q.buttons <= side_s[N].buttons;
			out_q.left_x <= side_s[N].left_x;
			out_q.left_y <= side_s[N].left_y;
			out_q.right_x <= side_s[N].right_x;
			out_q.right_y <= side_s[N].right_y;
			out_q.accel_x <= grd_pkg::sat16(side_s[N].res_neg[0], dvd_s[N][0]);
			out_q.accel_y <= grd_pkg::sat16(side_s[N].res_neg[1], dvd_s[N][1]);
			out_q.accel_z <= grd_pkg::sat16(side_s[N].res_neg[2], dvd_s[N][2]);
		end
	end

endmodule

// ----- design/gamepad_report_decoder_top.sv -----
// Path from input beat to output beat: queue, scale register, 26 divider stages
// for UNITS_PER_G of 512, output register. Throughput: one report per cycle while
// out_stall does not hold the pipeline; the divider is pipelined one quotient bit
// per stage. Reset: arst_n clears queue, pipeline valids and the output valid;
// offsets go to 0, scales to 0x4000. Configuration writes are taken every cycle.
module gamepad_report_decoder_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input grd_pkg::grd_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output grd_pkg::grd_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic push, pop, q_full, q_empty;
	grd_pkg::grd_item_t push_item, pop_item;
	grd_pkg::grd_div_t div_cfg;

	grd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_full(q_full), .push(push), .push_item(push_item), .div_cfg(div_cfg)
	);

	grd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .pop_item(pop_item), .empty(q_empty)
	);

	grd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_item(pop_item), .pop(pop), .div_cfg(div_cfg),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

// ----- design/grd_port_check.sv -----
// Port-level checks of the gamepad report decoder, bound to the top level.
// Uses grd_pkg and gamepad_report_decoder_top_assert.svh.
`include "gamepad_report_decoder_top_assert.svh"

module grd_port_check (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input grd_pkg::grd_out_t out_data
);

	`GRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output beat dropped")
	`GRD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled beat changed")
	`GRD_ASSERT_NOW(a_rej_plain, out_valid && !out_data.accepted, out_data.buttons == '0 && out_data.left_x == '0 && out_data.left_y == '0 && out_data.right_x == '0 && out_data.right_y == '0, "rejected beat carries input data")
	`GRD_ASSERT_NOW(a_rej_accel, out_valid && !out_data.accepted, out_data.accel_x == '0 && out_data.accel_y == '0 && out_data.accel_z == '0, "rejected beat carries acceleration")

endmodule

bind gamepad_report_decoder_top grd_port_check u_port_check (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
